### hw/rtl/lcf_pkg.sv
package lcf_pkg;

  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 64;
  localparam int STATE_W = 3;
  localparam int SLOT_W  = 3;

  // in_tdata: addr, fill_data, fill_state
  localparam int IN_FIELDS_W  = ADDR_W + DATA_W + STATE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  // out_tdata: hit, read_data, slot, writeback_valid, writeback_addr, writeback_data
  localparam int OUT_FIELDS_W = 1 + DATA_W + SLOT_W + 1 + ADDR_W + DATA_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // coherence state codes; codes above ST_M are stored but never readable
  localparam logic [STATE_W-1:0] ST_I = 3'd0;
  localparam logic [STATE_W-1:0] ST_S = 3'd1;
  localparam logic [STATE_W-1:0] ST_E = 3'd2;
  localparam logic [STATE_W-1:0] ST_O = 3'd3;
  localparam logic [STATE_W-1:0] ST_M = 3'd4;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_FILL = 1'b1;

  // request token walking down the row of lines
  typedef struct packed {
    logic                vld;
    logic                op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   fill_data;
    logic [STATE_W-1:0]  fill_state;
    logic                match_seen;   // an upstream line already matched addr
    logic                hit_seen;     // an upstream line already gave a read hit
    logic [DATA_W-1:0]   hit_data;
    logic [SLOT_W-1:0]   hit_slot;
  } tok_t;

  // update broadcast to every line at the end of the walk
  typedef struct packed {
    logic                commit;
    logic                fill;
    logic                no_match;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   fill_data;
    logic [STATE_W-1:0]  fill_state;
  } cmd_t;

  // per-line view returned to the top level
  typedef struct packed {
    logic                tgt;
    logic [STATE_W-1:0]  state;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } line_t;

  function automatic logic readable(input logic [STATE_W-1:0] s);
    return (s == ST_S) || (s == ST_E) || (s == ST_O) || (s == ST_M);
  endfunction

endpackage

### hw/rtl/lru_cache_fill_and_lookup_unit.sv
// channel | dir | tdata (low bit up)                                 | tuser
// in_     | in  | addr[31:0], fill_data[95:32], fill_state[98:96]    | op
// out_    | out | hit, read_data, slot, writeback_valid,             | -
//         |     | writeback_addr, writeback_data (bits 0..164)       |
// One item at a time: the request walks one line per cycle down the row of WAYS
// line cells, then the commit loads the output register and, for a fill,
// updates lines and ranks. A stalled output holds the request in the last cell;
// in_tready stays low until the commit. Reset (rst_n low, synchronous)
// invalidates all lines and sets each line's rank to its index.
module lru_cache_fill_and_lookup_unit #(
  parameter int WAYS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // addr, fill_data, fill_state
  input  logic [lcf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit, read_data, slot, writeback_valid, writeback_addr, writeback_data
  output logic [lcf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lcf_pkg::*;

  localparam int IDX_W = $clog2(WAYS);

  tok_t               tok_c [WAYS+1];
  line_t              line_c [WAYS];
  logic [IDX_W-1:0]   rank_c [WAYS];
  logic [WAYS-1:0]    tgt_vec;
  logic [WAYS-1:0]    tok_vld_vec;
  tok_t               last;
  cmd_t               cmd;
  logic               commit;
  logic               busy_r, busy_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [SLOT_W-1:0]  fill_slot;
  logic [IDX_W-1:0]   tr;
  logic               wb_vld;
  logic [ADDR_W-1:0]  wb_addr;
  logic [DATA_W-1:0]  wb_data;

  assign in_tready = !busy_r;

  assign tok_c[0] = '{vld: in_tvalid && in_tready, op: in_tuser,
                      addr: in_tdata[ADDR_W-1:0],
                      fill_data: in_tdata[ADDR_W+DATA_W-1:ADDR_W],
                      fill_state: in_tdata[IN_FIELDS_W-1:ADDR_W+DATA_W],
                      default: '0};

  assign last   = tok_c[WAYS];
  assign commit = last.vld && (!out_vld_r || out_tready);

  assign cmd = '{commit: commit, fill: (last.op == OP_FILL), no_match: !last.match_seen,
                 addr: last.addr, fill_data: last.fill_data, fill_state: last.fill_state};

  for (genvar g = 0; g < WAYS; g++) begin : g_line
    lcf_cell #(.WAYS(WAYS), .IDX(g), .IDX_W(IDX_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok_c[g]),
      .take_i ((g == WAYS - 1) ? commit : 1'b1),
      .tok_o  (tok_c[g+1]),
      .cmd_i  (cmd),
      .tr_i   (tr),
      .rank_o (rank_c[g]),
      .line_o (line_c[g])
    );
    assign tgt_vec[g]     = line_c[g].tgt;
    assign tok_vld_vec[g] = tok_c[g+1].vld;
  end

  // exactly one line is the target, so OR-ing selects it
  always_comb begin
    fill_slot = '0;
    tr        = '0;
    wb_vld    = 1'b0;
    wb_addr   = '0;
    wb_data   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (line_c[i].tgt) begin
        fill_slot = fill_slot | SLOT_W'(i);
        tr        = tr | rank_c[i];
        if (line_c[i].state == ST_M) begin
          wb_vld  = 1'b1;
          wb_addr = wb_addr | line_c[i].addr;
          wb_data = wb_data | line_c[i].data;
        end
      end
    end
  end

  always_comb begin
    busy_nxt     = busy_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (in_tvalid && in_tready)
      busy_nxt = 1'b1;
    if (out_vld_r && out_tready)
      out_vld_nxt = 1'b0;
    if (commit) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      if (last.op == OP_FILL)
        out_data_nxt = OUT_TDATA_W'({wb_data, wb_addr, wb_vld, fill_slot,
                                     {DATA_W{1'b0}}, 1'b0});
      else
        out_data_nxt = OUT_TDATA_W'({{DATA_W{1'b0}}, {ADDR_W{1'b0}}, 1'b0,
                                     last.hit_slot, last.hit_data, last.hit_seen});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && last.op == OP_FILL) |-> $onehot(tgt_vec))
    else $error("fill commit without exactly one target line");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_tvalid && !busy_r))
    else $error("commit did not load the output register");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vld_vec) |-> busy_r)
    else $error("request in the line row while idle");

endmodule

### hw/rtl/lcf_cell.sv
module lcf_cell #(
  parameter int WAYS = 8,
  parameter int IDX  = 0,
  parameter int IDX_W = $clog2(WAYS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcf_pkg::tok_t      tok_i,
  input  logic               take_i,
  output lcf_pkg::tok_t      tok_o,
  input  lcf_pkg::cmd_t      cmd_i,
  input  logic [IDX_W-1:0]   tr_i,
  output logic [IDX_W-1:0]   rank_o,
  output lcf_pkg::line_t     line_o
);
  import lcf_pkg::*;

  logic [DATA_W-1:0]  data_r,  data_nxt;
  logic [ADDR_W-1:0]  addr_r,  addr_nxt;
  logic [STATE_W-1:0] state_r, state_nxt;
  logic [IDX_W-1:0]   rank_r,  rank_nxt;
  logic               first_r, first_nxt;
  tok_t               tok_r,   tok_nxt;
  logic               match;
  logic               tgt;

  assign match = (tok_i.addr == addr_r);
  // target: lowest matching line, else the least recently filled line (rank zero is unique)
  assign tgt   = cmd_i.no_match ? (rank_r == '0) : first_r;

  always_comb begin
    tok_nxt   = tok_r;
    first_nxt = first_r;
    if (tok_i.vld) begin
      tok_nxt   = tok_i;
      first_nxt = match && !tok_i.match_seen;
      if (match)
        tok_nxt.match_seen = 1'b1;
      if (tok_i.op == OP_READ && match && readable(state_r) && !tok_i.hit_seen) begin
        tok_nxt.hit_seen = 1'b1;
        tok_nxt.hit_data = data_r;
        tok_nxt.hit_slot = SLOT_W'(IDX);
      end
    end else if (take_i) begin
      tok_nxt.vld = 1'b0;
    end
  end

  always_comb begin
    data_nxt  = data_r;
    addr_nxt  = addr_r;
    state_nxt = state_r;
    rank_nxt  = rank_r;
    if (cmd_i.commit && cmd_i.fill) begin
      if (tgt) begin
        data_nxt  = cmd_i.fill_data;
        addr_nxt  = cmd_i.addr;
        state_nxt = cmd_i.fill_state;
        rank_nxt  = IDX_W'(WAYS - 1);
      end else if (rank_r >= tr_i && rank_r != '0) begin
        rank_nxt = rank_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r    <= '0;
      addr_r    <= '0;
      state_r   <= ST_I;
      rank_r    <= IDX_W'(IDX);
      first_r   <= 1'b0;
      tok_r     <= '0;
    end else begin
      data_r    <= data_nxt;
      addr_r    <= addr_nxt;
      state_r   <= state_nxt;
      rank_r    <= rank_nxt;
      first_r   <= first_nxt;
      tok_r     <= tok_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign rank_o = rank_r;
  assign line_o = '{tgt: tgt, state: state_r, addr: addr_r, data: data_r};

endmodule
